>>> rtl/fdes_pkg.sv
// types and constants shared by the directory entry scan unit
`default_nettype none

package fdes_pkg;

   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_TUSER_W = 3;

   localparam logic [7:0] SLOT_END  = 8'h00;
   localparam logic [7:0] SLOT_GONE = 8'hE5;
   localparam logic [7:0] ATTR_LFN  = 8'h0F;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_SPC  = 8'h20;
   localparam int         ATTR_VOL_BIT = 3;
   localparam int         ATTR_DIR_BIT = 4;
   localparam int         LFN_LAST_BIT = 6;
   localparam logic [7:0] LFN_CHARS = 8'd13;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam logic KIND_BEGIN = 1'b0;
   localparam logic KIND_SLOT  = 1'b1;

   typedef enum logic [2:0] {
      ST_PENDING = 3'd0,
      ST_END     = 3'd1,
      ST_SHORT   = 3'd2,
      ST_LONG    = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   // lowest bits last
   typedef struct packed {
      logic [6:0]  pad;
      logic [15:0] date_in;
      logic [15:0] time_in;
      logic [31:0] size_in;
      logic [15:0] cluster_low;
      logic [15:0] cluster_high;
      logic [7:0]  attr_byte;
      logic [7:0]  second_name_byte;
      logic [7:0]  first_name_byte;
      logic        long_names;
      logic [15:0] wanted_index;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic        name_piece_last;
      logic        name_piece_valid;
      logic [7:0]  name_offset;
      logic [15:0] found_date;
      logic [15:0] found_time;
      logic [7:0]  found_attributes;
      logic [31:0] found_size;
      logic [31:0] found_cluster;
      logic [15:0] entry_number;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] visible_count;
      logic        long_name_ready;
      logic        scan_active;
      logic [15:0] target_entry;
      logic        long_mode;
   } scan_state_type;

endpackage

`default_nettype wire

>>> rtl/fdes_slot_eval.sv
// next scan state and result for one item
`default_nettype none

module fdes_slot_eval
   import fdes_pkg::*;
(
   input  scan_state_type cur_state,
   input  logic           kind,
   input  req_data_type   req,
   output scan_state_type nxt_state,
   output status_type     status,
   output rsp_data_type   rsp
);

   logic        found;
   logic        is_dot;
   logic        is_vol;
   logic        at_target;
   logic [15:0] bumped;
   logic [3:0]  seq_idx;

   assign is_dot = (req.first_name_byte == CHAR_DOT) && (req.second_name_byte == CHAR_SPC)
                   && req.attr_byte[ATTR_DIR_BIT];
   assign is_vol = req.attr_byte[ATTR_VOL_BIT];
   assign at_target = (cur_state.visible_count == cur_state.target_entry);
   assign bumped = (cur_state.visible_count == COUNT_MAX) ? cur_state.visible_count
                   : cur_state.visible_count + 16'd1;
   assign seq_idx = req.first_name_byte[3:0] - 4'd1;

   always_comb begin
      nxt_state = cur_state;
      status    = ST_PENDING;
      found     = 1'b0;
      rsp       = '0;
      if (kind == KIND_BEGIN) begin
         nxt_state.target_entry    = req.wanted_index;
         nxt_state.long_mode       = req.long_names;
         nxt_state.visible_count   = '0;
         nxt_state.long_name_ready = 1'b0;
         nxt_state.scan_active     = 1'b1;
      end else if (!cur_state.scan_active) begin
         status = ST_IGNORED;
      end else if (req.first_name_byte == SLOT_END) begin
         status = ST_END;
         nxt_state.scan_active = 1'b0;
      end else if (req.first_name_byte == SLOT_GONE) begin
         status = ST_PENDING;
      end else if (req.attr_byte == ATTR_LFN) begin
         if (cur_state.long_mode) begin
            rsp.name_offset      = 8'({4'd0, seq_idx} * LFN_CHARS);
            rsp.name_piece_valid = 1'b1;
            rsp.name_piece_last  = req.first_name_byte[LFN_LAST_BIT];
            if (req.first_name_byte[3:0] == 4'd1) begin
               nxt_state.long_name_ready = 1'b1;
            end
         end
      end else if (cur_state.long_name_ready) begin
         if (at_target) begin
            status = ST_LONG;
            found  = 1'b1;
            nxt_state.scan_active = 1'b0;
         end else begin
            nxt_state.long_name_ready = 1'b0;
            nxt_state.visible_count   = bumped;
         end
      end else if (!(is_dot || is_vol)) begin
         if (at_target) begin
            status = ST_SHORT;
            found  = 1'b1;
            nxt_state.scan_active = 1'b0;
         end else begin
            nxt_state.visible_count = bumped;
         end
      end
      rsp.entry_number = nxt_state.visible_count;
      if (found) begin
         rsp.found_cluster    = {req.cluster_high, req.cluster_low};
         rsp.found_size       = req.size_in;
         rsp.found_attributes = req.attr_byte;
         rsp.found_time       = req.time_in;
         rsp.found_date       = req.date_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/fat_directory_entry_scan_unit.sv
// top level of the directory entry scan unit
//
//   channel   dir   tdata                          tuser
//   req_      in    slot or begin fields (144 b)   kind
//   rsp_      out   entry and found fields (136 b) status
//
// one item a cycle while results are taken; each item passes from accept to result
// through the input register, then the result register; scan state updates as an
// item leaves the input register, so back to back slots see each other's effect
// synchronous reset clears the scan state and both valid flags
// a stalled result holds; the input register keeps taking items while the result is taken
`default_nettype none

module fat_directory_entry_scan_unit
   import fdes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // wanted_index, long_names, first_name_byte, second_name_byte, attr_byte,
   // cluster_high, cluster_low, size_in, time_in, date_in, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // entry_number, found_cluster, found_size, found_attributes, found_time,
   // found_date, name_offset, name_piece_valid, name_piece_last, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   logic                   in_valid_ff;
   logic                   in_kind_ff;
   req_data_type           in_data_ff;
   scan_state_type         state_ff;
   scan_state_type         state_in;
   logic                   out_valid_ff;
   status_type             out_status_ff;
   rsp_data_type           out_data_ff;
   status_type             status_in;
   rsp_data_type           data_in;
   logic                   advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   fdes_slot_eval u_eval (
      .cur_state (state_ff),
      .kind      (in_kind_ff),
      .req       (in_data_ff),
      .nxt_state (state_in),
      .status    (status_in),
      .rsp       (data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_data_type'(req_tdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= status_in;
         out_data_ff   <= data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

>>> rtl/fdes_checker.sv
// port level checks for the directory entry scan unit
`default_nettype none

module fdes_checker
   import fdes_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   rsp_data_type rsp;
   assign rsp = rsp_data_type'(rsp_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result shown or input blocked right after reset");

   a_piece_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.name_piece_valid |-> rsp_tuser == ST_PENDING)
      else $error("long name piece with final status");

   a_last_needs_piece: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.name_piece_valid |-> !rsp.name_piece_last && rsp.name_offset == 8'd0)
      else $error("piece fields set without a piece");

   a_found_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_SHORT && rsp_tuser != ST_LONG
      |-> rsp.found_cluster == 32'd0 && rsp.found_size == 32'd0
          && rsp.found_attributes == 8'd0)
      else $error("found fields set without a match");

endmodule

bind fat_directory_entry_scan_unit fdes_checker u_fdes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
